[design/ptws_pkg.sv]
`default_nettype none

package ptws_pkg;

  // Fixed field widths of the item and register formats.
  localparam int PART_W = 4;
  localparam int TICK_W = 16;
  localparam int SLOT_W = 4;
  localparam int WCNT_W = 5;
  localparam int CMD_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes carried by an input item.
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_IDLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_PART = 2'd2;

  // Register reset values.
  localparam logic [TICK_W-1:0] MAJOR_FRAME_RST = 16'd1000;
  localparam logic [WCNT_W-1:0] WINDOW_COUNT_RST = 5'd1;
  localparam logic [PART_W-1:0] IDLE_PART_RST = 4'd0;

  // One window table entry.
  typedef struct packed {
    logic [PART_W-1:0] part;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] dur;
  } entry_t;

endpackage

`default_nettype wire

[design/partition_time_window_scheduler_unit.sv]
`default_nettype none

// Time-window partition scheduler. Items are accepted one per clock cycle: a tick command
// yields one result (the partition to run and a frame restart flag), an idle request or a
// window table write yields none. An accepted item is registered in the stage and executed there;
// a tick's result is loaded into the output register at the end of the cycle in which it executes,
// which raises out_valid. The input stalls only when a tick in the stage meets a full output
// register that is not being read. The window table is a memory with two registered read ports
// that always hold the current window and the one after it; window 0's partition is kept in a
// register of its own for frame restarts. The table has no reset and no clearing pass: every
// window that the schedule can reach must be written before ticks are sent.
module partition_time_window_scheduler_unit #(
  parameter int MAX_WINDOWS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Configuration write channel.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ptws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ptws_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input item channel.
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [ptws_pkg::CMD_W-1:0]       in_command,
  input  wire logic [ptws_pkg::SLOT_W-1:0]      in_entry_index,
  input  wire logic [ptws_pkg::PART_W-1:0]      in_entry_partition,
  input  wire logic [ptws_pkg::TICK_W-1:0]      in_entry_start,
  input  wire logic [ptws_pkg::TICK_W-1:0]      in_entry_duration,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ptws_pkg::PART_W-1:0]           out_active_partition,
  output logic                                  out_frame_restart
);

  localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_BASE = $clog2(MAX_WINDOWS + 1);
  localparam int CNT_W = ((ptws_pkg::WCNT_W > CNT_BASE) ? ptws_pkg::WCNT_W : CNT_BASE) + 1;
  localparam int PART_W = ptws_pkg::PART_W;
  localparam int TICK_W = ptws_pkg::TICK_W;

  // Configuration registers.
  logic [TICK_W-1:0]           major_r;
  logic [ptws_pkg::WCNT_W-1:0] wcnt_r;
  logic [PART_W-1:0]           idle_part_r;

  // Input stage.
  logic                        stg_vld_r;
  logic [ptws_pkg::CMD_W-1:0]  stg_cmd_r;
  logic [ptws_pkg::SLOT_W-1:0] stg_slot_r;
  ptws_pkg::entry_t            stg_ent_r;

  // Scheduler state.
  logic [IDX_W-1:0]            cur_r, cur_nxt;
  logic [TICK_W-1:0]           ft_r, ft_nxt;
  logic                        idle_pend_r, idle_pend_nxt;
  logic [PART_W-1:0]           part0_r;

  // Window table and its read registers.
  ptws_pkg::entry_t            mem [MAX_WINDOWS];
  ptws_pkg::entry_t            rd_cur_r, rd_nxt_r;
  logic [IDX_W-1:0]            nxt_addr;

  // Output register.
  logic                        out_vld_r;
  logic [PART_W-1:0]           out_part_r;
  logic                        out_rst_r;

  // Control and datapath signals.
  logic                        stg_go, tick_go, wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [TICK_W:0]             ent_end;
  logic [PART_W-1:0]           cand, res_part;
  logic                        res_rst;
  logic [CNT_W-1:0]            eff_n, wcnt_ext, cur_p1;
  logic                        is_last;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r     <= ptws_pkg::MAJOR_FRAME_RST;
      wcnt_r      <= ptws_pkg::WINDOW_COUNT_RST;
      idle_part_r <= ptws_pkg::IDLE_PART_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ptws_pkg::REG_MAJOR_FRAME:  major_r <= cfg_data;
        ptws_pkg::REG_WINDOW_COUNT: wcnt_r <= cfg_data[ptws_pkg::WCNT_W-1:0];
        ptws_pkg::REG_IDLE_PART:    idle_part_r <= cfg_data[PART_W-1:0];
        default: ;
      endcase
    end
  end

  // The stage moves on unless a tick meets a full, stalled output register.
  assign stg_go  = stg_vld_r &&
                   ((stg_cmd_r != ptws_pkg::CMD_TICK) || !out_vld_r || out_ready);
  assign tick_go = stg_go && (stg_cmd_r == ptws_pkg::CMD_TICK);
  assign in_ready = !stg_vld_r || stg_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_cmd_r       <= in_command;
      stg_slot_r      <= in_entry_index;
      stg_ent_r.part  <= in_entry_partition;
      stg_ent_r.start <= in_entry_start;
      stg_ent_r.dur   <= in_entry_duration;
    end
  end

  // Effective window count, clamped to one and to the table depth.
  always_comb begin
    wcnt_ext = CNT_W'(wcnt_r);
    if (wcnt_ext == '0) begin
      eff_n = CNT_W'(1);
    end else if (wcnt_ext > CNT_W'(MAX_WINDOWS)) begin
      eff_n = CNT_W'(MAX_WINDOWS);
    end else begin
      eff_n = wcnt_ext;
    end
    cur_p1  = CNT_W'(cur_r) + CNT_W'(1);
    is_last = (cur_p1 >= eff_n);
  end

  // Tick evaluation and state update for the item in the stage.
  always_comb begin
    cur_nxt       = cur_r;
    ft_nxt        = ft_r;
    idle_pend_nxt = idle_pend_r;
    res_rst       = 1'b0;
    ent_end       = {1'b0, rd_cur_r.start} + {1'b0, rd_cur_r.dur};
    cand          = idle_pend_r ? idle_part_r : rd_cur_r.part;
    res_part      = cand;
    if (stg_go) begin
      case (stg_cmd_r)
        ptws_pkg::CMD_IDLE: begin
          idle_pend_nxt = 1'b1;
        end
        ptws_pkg::CMD_TICK: begin
          idle_pend_nxt = 1'b0;
          if (ft_r >= major_r) begin
            ft_nxt   = TICK_W'(1);
            cur_nxt  = '0;
            res_part = part0_r;
            res_rst  = 1'b1;
          end else begin
            ft_nxt = ft_r + TICK_W'(1);
            if ({1'b0, ft_r} >= ent_end) begin
              if (is_last) begin
                res_part = idle_part_r;
              end else begin
                cur_nxt  = cur_r + IDX_W'(1);
                res_part = rd_nxt_r.part;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      ft_r        <= TICK_W'(1);
      idle_pend_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      ft_r        <= ft_nxt;
      idle_pend_r <= idle_pend_nxt;
    end
  end

  // Table write; slots beyond the table depth are dropped.
  assign wr_en   = stg_go && (stg_cmd_r == ptws_pkg::CMD_WRITE) &&
                   (32'(stg_slot_r) < 32'(MAX_WINDOWS));
  assign wr_addr = IDX_W'(stg_slot_r);
  assign nxt_addr = cur_nxt + IDX_W'(1);

  // Read registers follow the window index, with a write in the same cycle forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= stg_ent_r;
    end
    if (wr_en && (wr_addr == cur_nxt)) begin
      rd_cur_r <= stg_ent_r;
    end else begin
      rd_cur_r <= mem[cur_nxt];
    end
    if (wr_en && (wr_addr == nxt_addr)) begin
      rd_nxt_r <= stg_ent_r;
    end else begin
      rd_nxt_r <= mem[nxt_addr];
    end
    if (wr_en && (wr_addr == '0)) begin
      part0_r <= stg_ent_r.part;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (tick_go) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      out_part_r <= res_part;
      out_rst_r  <= res_rst;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_active_partition = out_part_r;
  assign out_frame_restart    = out_rst_r;

  // A frame restart leaves the counter at one and the index at window zero.
  a_restart_state: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_go && res_rst) |=> (ft_r == TICK_W'(1) && cur_r == '0))
    else $error("frame restart did not reset counter and index");

  // Any executed tick consumes a pending idle request.
  a_idle_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> !idle_pend_r)
    else $error("idle request survived a tick");

  // The window index holds, steps by one, or returns to zero.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (cur_r == $past(cur_r) || cur_r == $past(cur_r) + IDX_W'(1) || cur_r == '0))
    else $error("window index jumped");

  // Input back-pressure only comes from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a stalled result");

endmodule

`default_nettype wire
